@@ src/hmmd_pkg.sv @@
// hmmd_pkg: types and constants for the handheld memory map decoder
// no dependencies
package hmmd_pkg;
	localparam int WORK_BANKS = 8;
	localparam int DMA_LENGTH = 160;
	localparam int BANK_W = $clog2(WORK_BANKS);
	localparam int WRAM_AW = $clog2(WORK_BANKS * 4096);

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		TGT_INTERNAL = 3'd0,
		TGT_CART_ROM = 3'd1,
		TGT_VRAM = 3'd2,
		TGT_CART_RAM = 3'd3,
		TGT_OAM = 3'd4,
		TGT_PALETTE = 3'd5
	} target_t;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] bus_address;
		logic [7:0] write_byte;
		logic [9:0] tick_cycles;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [2:0] target;
		logic [15:0] forward_address;
		logic dma_busy;
		logic [7:0] dma_left;
		logic video_bank;
	} out_item_t;

	// apb byte address of color_mode
	localparam logic [1:0] REG_COLOR_MODE = 2'd0;
endpackage

@@ src/hmmd_if.sv @@
// hmmd_if: valid/ready channel carrying one item
// depends on hmmd_pkg
interface hmmd_in_if;
	logic valid;
	logic ready;
	hmmd_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hmmd_out_if;
	logic valid;
	logic ready;
	hmmd_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/hmmd_wram.sv @@
// hmmd_wram: banked work ram, one write or read port, registered read data
// depends on hmmd_pkg
module hmmd_wram (
	input logic clk,
	input logic we,
	input logic re,
	input logic [hmmd_pkg::WRAM_AW-1:0] addr,
	input logic [7:0] wdata,
	output logic [7:0] rdata
);
	logic [7:0] mem [0:(hmmd_pkg::WORK_BANKS*4096)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ src/handheld_memory_map_decoder_core.sv @@
// handheld_memory_map_decoder_core: top level of the memory map decoder
// depends on hmmd_pkg, hmmd_if, hmmd_wram
// Usage
// Items arrive on in_ch (op, bus_address, write_byte, tick_cycles) and each
// gives exactly one result item on out_ch. An item is accepted when valid and
// ready are both high. The decoder works on one item at a time: stage one
// decodes, updates the control state and issues the work ram, high ram and io
// page reads; stage two takes the registered read data, writes the io page and
// loads the output register. An item passes from acceptance through the stage
// two registers into the output register; a new item is taken only once the
// previous result has been loaded into the output register, since the rams
// give registered read data.
// When the receiver stalls, the result waits in the output register and one
// further item may be decoded and held in stage two until the output frees.
// color_mode is written over the apb port at address 0. Reset clears the io
// page valid flags and resets the control registers and dma state at once, so
// stored io bytes count as zero until written; work ram and high ram are not
// cleared and read undefined until written.
module handheld_memory_map_decoder_core (
	input logic clk,
	input logic arst_n,
	hmmd_in_if.sink in_ch,
	hmmd_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic color_mode_q;
	logic [7:0] io_mem [0:127];
	logic [127:0] io_vld_q;
	logic [7:0] hram [0:127];
	logic [2:0] work_bank_q;
	logic [7:0] irq_enable_q;
	logic boot_off_q;
	logic [15:0] dma_source_q;
	logic [7:0] dma_count_q;
	logic dma_on_q;
	logic vram_bank_q;

	// stage two holds one item waiting for ram data
	logic busy_s2;
	logic from_wram_s2, from_hram_s2;
	hmmd_pkg::out_item_t res_s2;
	logic [7:0] hram_rd_s2;
	logic [7:0] wram_rd;
	logic [7:0] io_rdata_s2;
	logic io_vld_s2;
	logic [6:0] r_s2;
	logic io_we_s2;
	logic [7:0] io_keep_s2, io_wval_s2, rd_and_s2;
	logic out_valid_q;
	hmmd_pkg::out_item_t out_q;

	assign pready = 1'b1;
	assign prdata = {31'd0, color_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == hmmd_pkg::REG_COLOR_MODE) begin
			color_mode_q <= pwdata[0];
		end
	end

	logic s2_free;
	assign s2_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !busy_s2;
	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	hmmd_pkg::in_item_t it;
	assign it = in_ch.data;
	logic [15:0] a;
	assign a = it.bus_address;
	logic [6:0] r;
	assign r = a[6:0];
	logic rw, wr;
	assign rw = it.op == hmmd_pkg::OP_READ || it.op == hmmd_pkg::OP_WRITE;
	assign wr = it.op == hmmd_pkg::OP_WRITE;

	// wram address
	logic [hmmd_pkg::WRAM_AW-1:0] wram_addr;
	logic [hmmd_pkg::BANK_W-1:0] bank;
	logic [3:0] bank_mod;
	always_comb begin
		// bank number wraps modulo the bank count
		bank_mod = {1'b0, work_bank_q};
		for (int k = 0; k < 3; k++) begin
			if (bank_mod >= 4'(hmmd_pkg::WORK_BANKS))
				bank_mod = bank_mod - 4'(hmmd_pkg::WORK_BANKS);
		end
		bank = bank_mod[hmmd_pkg::BANK_W-1:0];
		if (!a[12]) begin
			wram_addr = hmmd_pkg::WRAM_AW'(a[11:0]);
		end else begin
			wram_addr = {bank, a[11:0]};
		end
	end
	logic wram_hit;
	assign wram_hit = rw && a >= 16'hC000 && a < 16'hFE00;

	hmmd_wram u_wram (
		.clk(clk), .we(acc && wram_hit && wr), .re(acc && wram_hit && !wr),
		.addr(wram_addr), .wdata(it.write_byte), .rdata(wram_rd)
	);

	// io read decode: read byte is (stored byte & and-mask) | or-part
	logic [7:0] io_rd_and, io_rd_or;
	logic io_rd_hram;
	always_comb begin
		io_rd_hram = 1'b0;
		io_rd_and = 8'h00;
		io_rd_or = 8'h00;
		if (a == 16'hFF00) io_rd_and = 8'h30;
		else if (a == 16'hFF4D) begin
			io_rd_and = 8'h80;
			io_rd_or = 8'h7E;
		end else if (a == 16'hFF50) io_rd_or = boot_off_q ? 8'hFF : 8'h00;
		else if (a == 16'hFF70) begin
			io_rd_and = 8'h07;
			io_rd_or = 8'hF8;
		end else if (a == 16'hFF41) begin
			io_rd_and = 8'h87;
			io_rd_or = 8'h80;
		end else if ((a >= 16'hFF10 && a <= 16'hFF3F) || (a >= 16'hFF4C && a <= 16'hFF7F)
			|| (a >= 16'hFF04 && a <= 16'hFF07) || a == 16'hFF0F
			|| (a >= 16'hFF40 && a <= 16'hFF4B && a != 16'hFF46)) io_rd_and = 8'hFF;
		else if (a >= 16'hFF80 && a <= 16'hFFFE) io_rd_hram = 1'b1;
		else if (a == 16'hFFFF) io_rd_or = irq_enable_q;
		else io_rd_or = 8'hFF;
	end

	// result and state updates of one item
	hmmd_pkg::out_item_t res;
	logic is_wram_rd, is_hram_rd;
	logic [7:0] rd_and;
	logic [7:0] n;
	logic [7:0] cnt_n;
	logic [15:0] src_n;
	logic on_n, vb_n;
	logic [2:0] wb_n;
	always_comb begin
		res = '0;
		is_wram_rd = 1'b0;
		is_hram_rd = 1'b0;
		rd_and = 8'h00;
		cnt_n = dma_count_q;
		src_n = dma_source_q;
		on_n = dma_on_q;
		vb_n = vram_bank_q;
		wb_n = work_bank_q;
		n = (it.tick_cycles[9:2] > dma_count_q) ? dma_count_q : it.tick_cycles[9:2];
		if (rw) begin
			if (a < 16'h8000) begin
				res.target = hmmd_pkg::TGT_CART_ROM;
				res.forward_address = a;
			end else if (a < 16'hA000) begin
				res.target = hmmd_pkg::TGT_VRAM;
				res.forward_address = {3'd0, a[12:0]};
			end else if (a < 16'hC000) begin
				res.target = hmmd_pkg::TGT_CART_RAM;
				res.forward_address = a;
			end else if (a < 16'hFE00) begin
				is_wram_rd = !wr;
			end else if (a < 16'hFEA0) begin
				if (dma_on_q) begin
					res.read_byte = wr ? 8'h00 : 8'hFF;
				end else begin
					res.target = hmmd_pkg::TGT_OAM;
					res.forward_address = {8'd0, a[7:0]};
				end
			end else if (a < 16'hFF00) begin
				res.read_byte = wr ? 8'h00 : 8'hFF;
			end else if (wr) begin
				if (a >= 16'hFF68 && a <= 16'hFF6B) begin
					res.target = hmmd_pkg::TGT_PALETTE;
					res.forward_address = a;
				end
				if (a == 16'hFF4F && color_mode_q) vb_n = it.write_byte[0];
				if (a == 16'hFF70) wb_n = (it.write_byte[2:0] == 3'd0) ? 3'd1 : it.write_byte[2:0];
				if (a == 16'hFF46) begin
					src_n = {it.write_byte, 8'd0};
					cnt_n = 8'(hmmd_pkg::DMA_LENGTH);
					on_n = 1'b1;
				end
			end else begin
				res.read_byte = io_rd_or;
				rd_and = io_rd_and;
				is_hram_rd = io_rd_hram;
			end
		end else if (it.op == hmmd_pkg::OP_TICK && dma_on_q) begin
			cnt_n = dma_count_q - n;
			src_n = dma_source_q + {8'd0, n};
			if (cnt_n == 8'd0) on_n = 1'b0;
		end
		res.dma_busy = on_n;
		res.dma_left = cnt_n;
		res.video_bank = vb_n;
	end

	// io byte write: new byte is (stored byte & keep-mask) | write part
	logic [7:0] io_keep, io_wval;
	logic io_we;
	always_comb begin
		io_we = 1'b1;
		io_keep = 8'h00;
		io_wval = it.write_byte;
		if (a == 16'hFF00) begin
			io_keep = 8'hCF;
			io_wval = it.write_byte & 8'h30;
		end else if (a == 16'hFF4D) begin
			io_keep = 8'h80;
			io_wval = {7'd0, it.write_byte[0]};
		end else if (a == 16'hFF4F) begin
			io_we = color_mode_q;
			io_wval = {7'd0, it.write_byte[0]};
		end else if (a == 16'hFF50) io_wval = it.write_byte;
		else if (a >= 16'hFF68 && a <= 16'hFF6B) io_wval = it.write_byte;
		else if (a == 16'hFF70) io_wval = {5'd0, wb_n};
		else if (a == 16'hFF41) begin
			io_keep = 8'h78;
			io_wval = it.write_byte & 8'h87;
		end else if (a == 16'hFF44 || a == 16'hFF04) io_wval = 8'h00;
		else if (a == 16'hFF07) io_wval = it.write_byte & 8'h07;
		else if (a == 16'hFF46) io_we = 1'b0;
		else if ((a >= 16'hFF10 && a <= 16'hFF3F) || (a >= 16'hFF4C && a <= 16'hFF7F)
			|| (a >= 16'hFF40 && a <= 16'hFF4B) || a == 16'hFF0F || a == 16'hFF05
			|| a == 16'hFF06) io_wval = it.write_byte;
		else io_we = 1'b0;
	end
	logic do_io_w;
	assign do_io_w = acc && wr && a[15:7] == 9'h1FE && io_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_bank_q <= 3'd1;
			irq_enable_q <= 8'h00;
			boot_off_q <= 1'b0;
			dma_source_q <= 16'h0000;
			dma_count_q <= 8'h00;
			dma_on_q <= 1'b0;
			vram_bank_q <= 1'b0;
		end else if (acc) begin
			if (wr && a == 16'hFF50) boot_off_q <= 1'b1;
			if (wr && a == 16'hFFFF) irq_enable_q <= it.write_byte;
			work_bank_q <= wb_n;
			dma_source_q <= src_n;
			dma_count_q <= cnt_n;
			dma_on_q <= on_n;
			vram_bank_q <= vb_n;
		end
	end

	// io page read-modify-write; the write lands as the item leaves stage two,
	// before the next item can be taken
	logic [7:0] io_old, io_new;
	assign io_old = io_vld_s2 ? io_rdata_s2 : 8'h00;
	assign io_new = (io_old & io_keep_s2) | io_wval_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_vld_q <= '0;
			io_vld_s2 <= 1'b0;
			io_we_s2 <= 1'b0;
		end else begin
			if (acc) begin
				io_vld_s2 <= io_vld_q[r];
				io_we_s2 <= do_io_w;
			end
			if (busy_s2 && s2_free && io_we_s2) io_vld_q[r_s2] <= 1'b1;
		end
	end

	hmmd_pkg::out_item_t res_fin;
	always_comb begin
		res_fin = res_s2;
		if (from_wram_s2) res_fin.read_byte = wram_rd;
		else if (from_hram_s2) res_fin.read_byte = hram_rd_s2;
		else res_fin.read_byte = res_s2.read_byte | (io_old & rd_and_s2);
	end

	always_ff @(posedge clk) begin
		if (acc && wr && a >= 16'hFF80 && a <= 16'hFFFE) hram[r] <= it.write_byte;
		if (acc && is_hram_rd) hram_rd_s2 <= hram[r];
		if (acc) begin
			io_rdata_s2 <= io_mem[r];
			io_keep_s2 <= io_keep;
			io_wval_s2 <= io_wval;
			rd_and_s2 <= rd_and;
			r_s2 <= r;
			res_s2 <= res;
			from_wram_s2 <= is_wram_rd;
			from_hram_s2 <= is_hram_rd;
		end
		if (busy_s2 && s2_free && io_we_s2) io_mem[r_s2] <= io_new;
		if (busy_s2 && s2_free) out_q <= res_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_s2 && s2_free) busy_s2 <= 1'b0;
			else if (acc) busy_s2 <= 1'b1;
			if (busy_s2 && s2_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s2 |-> !in_ch.ready) else $error("item taken while stage two busy");
	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s2 && s2_free |=> out_valid_q) else $error("result lost");
	a_dma_count: assert property (@(posedge clk) disable iff (!arst_n)
		!dma_on_q |-> dma_count_q == 8'd0 || $past(dma_count_q) == dma_count_q)
		else $error("dma count moved while idle");
endmodule
